// File: hdl/keyframe_channel_sampler_top_macros.svh
// ----------------------------------------------------------------------------
// Keyframe channel sampler assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_CHANNEL_SAMPLER_TOP_MACROS_SVH
`define KEYFRAME_CHANNEL_SAMPLER_TOP_MACROS_SVH

// same-cycle implication
`define KCS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define KCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/kcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe channel sampler package
// Sizes, command and table entry types, register codes.
// ----------------------------------------------------------------------------
package kcs_pkg;

   localparam int MAX_KEYS = 64;
   localparam int IDX_W    = $clog2(MAX_KEYS);
   localparam int CNT_W    = $clog2(MAX_KEYS + 1);
   localparam int FRAC_W   = 16;
   localparam int SPAN_MIN = 7;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      REG_LOOP  = 2'd0,
      REG_CLIP  = 2'd1,
      REG_COUNT = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic        loop_enable;
      logic [31:0] clip_length;
      logic [6:0]  key_count;
   } cfg_type;

   // decoded transaction handed from front to back
   typedef struct packed {
      logic               is_sample;
      logic [IDX_W-1:0]   idx;
      logic [31:0]        kt;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               hold;
      logic signed [31:0] sample_time;
   } cmd_type;

   // one keyframe table row
   typedef struct packed {
      logic [31:0]        kt;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               hold;
   } key_type;

endpackage

// File: hdl/kcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe sampler front end
// Accepts request transactions, clamps key time, registers a command.
// ----------------------------------------------------------------------------
module kcs_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic [5:0]               req_key_index,
   input  logic signed [31:0]       req_key_time,
   input  logic signed [31:0]       req_key_x,
   input  logic signed [31:0]       req_key_y,
   input  logic signed [31:0]       req_key_z,
   input  logic                     req_key_hold,
   input  logic signed [31:0]       req_sample_time,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output kcs_pkg::cmd_type         cmd
);
   import kcs_pkg::*;

   logic    valid_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;

   assign req_ready = !valid_ff || cmd_ready;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   // classify and clamp negative key times to zero
   always_comb begin
      cmd_in.is_sample   = (req_func == FUNC_SAMPLE);
      cmd_in.idx         = req_key_index[IDX_W-1:0];
      cmd_in.kt          = req_key_time[31] ? 32'd0 : req_key_time;
      cmd_in.x           = req_key_x;
      cmd_in.y           = req_key_y;
      cmd_in.z           = req_key_z;
      cmd_in.hold        = req_key_hold;
      cmd_in.sample_time = req_sample_time;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// File: hdl/kcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe sampler command queue
// Two-entry FIFO between front end and sample engine.
// ----------------------------------------------------------------------------
module kcs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  kcs_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output kcs_pkg::cmd_type out_cmd
);
   import kcs_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// File: hdl/kcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe sampler engine
// Key table, time wrap, key search, fraction divide and blend sequencer.
// ----------------------------------------------------------------------------
module kcs_back (
   input  logic                clock,
   input  logic                reset,
   input  kcs_pkg::cfg_type    cfg,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  kcs_pkg::cmd_type    cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_has_value,
   output logic signed [31:0]  rsp_value_x,
   output logic signed [31:0]  rsp_value_y,
   output logic signed [31:0]  rsp_value_z
);
   import kcs_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_WRAP, S_MOD, S_MODFIX, S_FIRST_RD, S_FIRST_CMP, S_LAST_RD,
      S_LAST_CMP, S_SRCH_RD, S_SRCH_CMP, S_A_RD, S_B_RD, S_B_CAP, S_DIV,
      S_MUL, S_ADD, S_OUT_RD, S_OUT_LD, S_EMIT
   } state_type;

   state_type          state_ff;
   key_type            mem [MAX_KEYS];
   key_type            rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;

   logic [31:0]        t_ff;
   logic               neg_ff;
   logic [32:0]        rem_ff;
   logic [31:0]        dvd_ff;
   logic [4:0]         cnt_ff;
   logic [CNT_W-1:0]   lo_ff;
   logic [CNT_W-1:0]   hi_ff;
   logic [IDX_W-1:0]   out_idx_ff;
   key_type            a_ff;
   key_type            b_ff;
   logic [31:0]        span_ff;
   logic [FRAC_W:0]    frac_ff;
   logic [1:0]         comp_ff;
   logic signed [50:0] prod_ff;
   logic               res_has_ff;
   logic signed [31:0] res_x_ff, res_y_ff, res_z_ff;
   logic               rsp_valid_ff;
   logic               rsp_has_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   logic [CNT_W-1:0]   n_eff;
   logic [CNT_W-1:0]   mid;
   logic [32:0]        mod_sh;
   logic [32:0]        div_sh;
   logic [31:0]        abs_t;
   logic signed [32:0] diff;
   logic signed [32:0] span_raw;
   logic [31:0]        span;
   logic signed [31:0] va, vb;
   logic signed [32:0] delta;
   logic signed [17:0] frac_s;
   logic               emit_go;

   // key count saturates at the table depth
   assign n_eff = (cfg.key_count > 7'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                 : CNT_W'(cfg.key_count);
   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign mod_sh = {rem_ff[31:0], dvd_ff[31]};
   assign div_sh = {rem_ff[31:0], 1'b0};
   assign abs_t  = cmd.sample_time[31] ? (~cmd.sample_time + 32'd1)
                                       : cmd.sample_time;
   assign cmd_ready = (state_ff == S_IDLE);
   assign mem_we    = (state_ff == S_IDLE) && cmd_valid && !cmd.is_sample;
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   // span and offset within the bracketing pair
   assign diff     = $signed({1'b0, t_ff}) - $signed({1'b0, a_ff.kt});
   assign span_raw = $signed({1'b0, rd_data_ff.kt}) - $signed({1'b0, a_ff.kt});
   assign span     = (span_raw < 33'sd7) ? 32'(SPAN_MIN) : span_raw[31:0];

   // blend operand select
   always_comb begin
      case (comp_ff)
         2'd0:    begin va = a_ff.x; vb = b_ff.x; end
         2'd1:    begin va = a_ff.y; vb = b_ff.y; end
         default: begin va = a_ff.z; vb = b_ff.z; end
      endcase
   end
   assign delta  = $signed({vb[31], vb}) - $signed({va[31], va});
   assign frac_s = $signed({1'b0, frac_ff});

   // table read address
   always_comb begin
      case (state_ff)
         S_LAST_RD: rd_addr = IDX_W'(n_eff - CNT_W'(1));
         S_SRCH_RD: rd_addr = mid[IDX_W-1:0];
         S_A_RD:    rd_addr = IDX_W'(lo_ff - CNT_W'(1));
         S_B_RD:    rd_addr = lo_ff[IDX_W-1:0];
         S_OUT_RD:  rd_addr = out_idx_ff;
         default:   rd_addr = '0;
      endcase
   end

   // key table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd.idx] <= '{kt: cmd.kt, x: cmd.x, y: cmd.y, z: cmd.z, hold: cmd.hold};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd.is_sample) begin
                  neg_ff     <= cmd.sample_time[31];
                  t_ff       <= cmd.sample_time;
                  dvd_ff     <= abs_t;
                  rem_ff     <= '0;
                  cnt_ff     <= 5'd31;
                  res_has_ff <= (n_eff != '0);
                  out_idx_ff <= '0;
                  if (n_eff == '0) begin
                     res_x_ff <= '0;
                     res_y_ff <= '0;
                     res_z_ff <= '0;
                     state_ff <= S_EMIT;
                  end else if (n_eff == CNT_W'(1)) begin
                     state_ff <= S_OUT_RD;
                  end else begin
                     state_ff <= S_WRAP;
                  end
               end
            end
            S_WRAP: begin
               if (cfg.clip_length == '0) begin
                  if (neg_ff) t_ff <= '0;
                  state_ff <= S_FIRST_RD;
               end else if (!cfg.loop_enable) begin
                  if (neg_ff) begin
                     t_ff <= '0;
                  end else if (t_ff > cfg.clip_length) begin
                     t_ff <= cfg.clip_length;
                  end
                  state_ff <= S_FIRST_RD;
               end else begin
                  state_ff <= S_MOD;
               end
            end
            // restoring remainder, one bit per cycle
            S_MOD: begin
               dvd_ff <= {dvd_ff[30:0], 1'b0};
               if (mod_sh >= {1'b0, cfg.clip_length}) begin
                  rem_ff <= mod_sh - {1'b0, cfg.clip_length};
               end else begin
                  rem_ff <= mod_sh;
               end
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == '0) state_ff <= S_MODFIX;
            end
            S_MODFIX: begin
               if (neg_ff && rem_ff[31:0] != '0) begin
                  t_ff <= cfg.clip_length - rem_ff[31:0];
               end else begin
                  t_ff <= rem_ff[31:0];
               end
               state_ff <= S_FIRST_RD;
            end
            S_FIRST_RD: state_ff <= S_FIRST_CMP;
            S_FIRST_CMP: begin
               if (t_ff <= rd_data_ff.kt) begin
                  out_idx_ff <= '0;
                  state_ff   <= S_OUT_RD;
               end else begin
                  state_ff <= S_LAST_RD;
               end
            end
            S_LAST_RD: state_ff <= S_LAST_CMP;
            S_LAST_CMP: begin
               lo_ff <= '0;
               hi_ff <= n_eff;
               if (t_ff >= rd_data_ff.kt) begin
                  out_idx_ff <= IDX_W'(n_eff - CNT_W'(1));
                  state_ff   <= S_OUT_RD;
               end else begin
                  state_ff <= S_SRCH_RD;
               end
            end
            // upper-bound binary search
            S_SRCH_RD: begin
               if (lo_ff < hi_ff) begin
                  state_ff <= S_SRCH_CMP;
               end else if (lo_ff >= n_eff) begin
                  out_idx_ff <= IDX_W'(n_eff - CNT_W'(1));
                  state_ff   <= S_OUT_RD;
               end else if (lo_ff == '0) begin
                  out_idx_ff <= '0;
                  state_ff   <= S_OUT_RD;
               end else begin
                  state_ff <= S_A_RD;
               end
            end
            S_SRCH_CMP: begin
               if (t_ff < rd_data_ff.kt) begin
                  hi_ff <= mid;
               end else begin
                  lo_ff <= mid + CNT_W'(1);
               end
               state_ff <= S_SRCH_RD;
            end
            S_A_RD: state_ff <= S_B_RD;
            S_B_RD: begin
               a_ff     <= rd_data_ff;
               state_ff <= S_B_CAP;
            end
            S_B_CAP: begin
               b_ff    <= rd_data_ff;
               span_ff <= span;
               rem_ff  <= diff;
               frac_ff <= '0;
               cnt_ff  <= 5'd15;
               comp_ff <= 2'd0;
               if (a_ff.hold) begin
                  res_x_ff <= a_ff.x;
                  res_y_ff <= a_ff.y;
                  res_z_ff <= a_ff.z;
                  state_ff <= S_EMIT;
               end else if (diff[32] || diff == '0) begin
                  state_ff <= S_MUL;
               end else if (diff[31:0] >= span) begin
                  frac_ff  <= (FRAC_W+1)'(1 << FRAC_W);
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            // fraction = diff * 2^16 / span, one quotient bit per cycle
            S_DIV: begin
               if (div_sh >= {1'b0, span_ff}) begin
                  rem_ff  <= div_sh - {1'b0, span_ff};
                  frac_ff <= {frac_ff[FRAC_W-1:0], 1'b1};
               end else begin
                  rem_ff  <= div_sh;
                  frac_ff <= {frac_ff[FRAC_W-1:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == '0) state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= delta * frac_s;
               state_ff <= S_ADD;
            end
            // floor shift of the product, then offset from the earlier key
            S_ADD: begin
               case (comp_ff)
                  2'd0:    res_x_ff <= va + prod_ff[47:16];
                  2'd1:    res_y_ff <= va + prod_ff[47:16];
                  default: res_z_ff <= va + prod_ff[47:16];
               endcase
               comp_ff  <= comp_ff + 2'd1;
               state_ff <= (comp_ff == 2'd2) ? S_EMIT : S_MUL;
            end
            S_OUT_RD: state_ff <= S_OUT_LD;
            S_OUT_LD: begin
               res_x_ff <= rd_data_ff.x;
               res_y_ff <= rd_data_ff.y;
               res_z_ff <= rd_data_ff.z;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (emit_go) begin
                  rsp_has_ff <= res_has_ff;
                  rsp_x_ff   <= res_x_ff;
                  rsp_y_ff   <= res_y_ff;
                  rsp_z_ff   <= res_z_ff;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_has_value = rsp_has_ff;
   assign rsp_value_x   = rsp_x_ff;
   assign rsp_value_y   = rsp_y_ff;
   assign rsp_value_z   = rsp_z_ff;

endmodule

// File: hdl/keyframe_channel_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe channel sampler top level
// Samples one three-component animation channel from a keyframe table.
// ----------------------------------------------------------------------------
// A keyframe write passes the front-end register and the command queue and is
// written into the table when the idle engine takes it. A sample passes these
// steps in the engine: accept, the looping time wrap with its 32-step
// remainder, the first and last key checks, the key search (seven steps over
// 64 keys and a final check), the fetch of the bracketing pair, the fraction
// divide, the blend multiply and add for each of the three components and the
// load of the result register. Without looping the remainder drops out. An
// empty or single-key table skips the wrap, the key checks and the search; a
// time at or before the first key or at or past the last skips the search, the
// divide and the blend, and a held key skips the divide and the blend. A result
// waits in its register until rsp_ready. The front end and a two-deep command
// queue keep accepting transactions while the engine works, until both are full.
// Registers: loop_enable at 0x0, clip_length at 0x4, key_count at 0x8.
module keyframe_channel_sampler_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [5:0]         req_key_index,
   input  logic signed [31:0] req_key_time,
   input  logic signed [31:0] req_key_x,
   input  logic signed [31:0] req_key_y,
   input  logic signed [31:0] req_key_z,
   input  logic               req_key_hold,
   input  logic signed [31:0] req_sample_time,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_has_value,
   output logic signed [31:0] rsp_value_x,
   output logic signed [31:0] rsp_value_y,
   output logic signed [31:0] rsp_value_z,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import kcs_pkg::*;

   cfg_type     cfg_ff;
   reg_idx_type reg_idx;
   cmd_type     f_cmd, q_cmd;
   logic        f_valid, f_ready, q_valid, q_ready;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_idx_type'(csr_paddr[3:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loop_enable <= 1'b1;
         cfg_ff.clip_length <= '0;
         cfg_ff.key_count   <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (reg_idx)
            REG_LOOP:  cfg_ff.loop_enable <= csr_pwdata[0];
            REG_CLIP:  cfg_ff.clip_length <= csr_pwdata;
            REG_COUNT: cfg_ff.key_count   <= csr_pwdata[6:0];
            default:   ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_idx)
         REG_LOOP:  csr_prdata = {31'd0, cfg_ff.loop_enable};
         REG_CLIP:  csr_prdata = cfg_ff.clip_length;
         REG_COUNT: csr_prdata = {25'd0, cfg_ff.key_count};
         default:   csr_prdata = '0;
      endcase
   end

   kcs_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_key_index,
      .req_key_time, .req_key_x, .req_key_y, .req_key_z, .req_key_hold,
      .req_sample_time,
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd       (f_cmd)
   );

   kcs_queue u_queue (
      .clock, .reset,
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   kcs_back u_back (
      .clock, .reset,
      .cfg       (cfg_ff),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .rsp_valid, .rsp_ready, .rsp_has_value, .rsp_value_x, .rsp_value_y,
      .rsp_value_z
   );

endmodule

// File: hdl/kcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe channel sampler checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyframe_channel_sampler_top_macros.svh"

module kcs_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_has_value,
   input logic signed [31:0] rsp_value_x,
   input logic signed [31:0] rsp_value_y,
   input logic signed [31:0] rsp_value_z,
   input logic               csr_psel,
   input logic               csr_pready
);

   logic        value_zero;
   logic [95:0] value_all;

   assign value_zero = (rsp_value_x == '0) && (rsp_value_y == '0) && (rsp_value_z == '0);
   assign value_all  = {rsp_value_x, rsp_value_y, rsp_value_z};

   // an empty table yields an all-zero value
   `KCS_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && !rsp_has_value, value_zero)

   // no result is pending right after reset
   `KCS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

   // a stalled result holds its value
   `KCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(value_all))

   // the register port never waits
   `KCS_ASSERT_NOW(a_csr_ready, clock, reset, csr_psel, csr_pready)

endmodule

bind keyframe_channel_sampler_top kcs_checker u_kcs_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe channel sampler testbench
// Drives keyframe writes and sample transactions into the sampler, programs
// loop mode, clip length and key count over the register port, and checks
// every sampled value against a behavioral interpolator kept in the bench or
// a value set in its directed row. A short directed table comes first, then
// random phases with different register settings and handshake idling.
// ----------------------------------------------------------------------------
module tb_top;
   import kcs_pkg::*;

   localparam int  CLK_HALF    = 6;
   localparam int  DRAIN_WAIT  = 120;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  NUM_PHASES  = 8;
   localparam int  PHASE_ITEMS = 180;

   typedef struct packed {
      logic               has;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } sampled_point;

   typedef enum logic [1:0] {ROW_KEY, ROW_SAMPLE, ROW_REG} row_kind;

   typedef struct {
      row_kind            kind;
      reg_idx_type        ridx;
      logic [31:0]        rval;
      logic [5:0]         idx;
      logic signed [31:0] kt;
      logic signed [31:0] kx;
      logic signed [31:0] ky;
      logic signed [31:0] kz;
      logic               hold;
      logic signed [31:0] st;
      bit                 typed;
      sampled_point       want;
   } stim_row;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_func = FUNC_WRITE;
   logic [5:0]         req_key_index = '0;
   logic signed [31:0] req_key_time = '0;
   logic signed [31:0] req_key_x = '0;
   logic signed [31:0] req_key_y = '0;
   logic signed [31:0] req_key_z = '0;
   logic               req_key_hold = 1'b0;
   logic signed [31:0] req_sample_time = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_has_value;
   logic signed [31:0] rsp_value_x;
   logic signed [31:0] rsp_value_y;
   logic signed [31:0] rsp_value_z;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // shadow of the block's registers and keyframe table
   logic               shadow_loop = 1'b1;
   logic [31:0]        shadow_clip = '0;
   logic [6:0]         shadow_count = '0;
   logic signed [31:0] kf_time [MAX_KEYS];
   logic signed [31:0] kf_x    [MAX_KEYS];
   logic signed [31:0] kf_y    [MAX_KEYS];
   logic signed [31:0] kf_z    [MAX_KEYS];
   logic               kf_hold [MAX_KEYS];

   sampled_point pending_points[$];
   stim_row      rows[$];
   int           mismatches = 0;
   int           samples_sent = 0;
   int           keys_sent = 0;
   int           reg_writes = 0;
   int           points_checked = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   bit           long_hold_req = 0;
   int           long_hold_left = 0;
   longint       cycles = 0;

   keyframe_channel_sampler_top dut (.*);

   // clock
   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  pending_points.size());
         $display("** keyframe_channel_sampler_top: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // interpolator
   // ---------------------------------------------------------------------
   function automatic longint wrap_sample_time(longint t);
      longint len;
      longint r;
      len = {32'd0, shadow_clip};
      if (len == 0) return (t < 0) ? 0 : t;
      if (!shadow_loop) begin
         if (t < 0) return 0;
         if (t > len) return len;
         return t;
      end
      r = t % len;
      if (r < 0) r += len;
      return r;
   endfunction

   function automatic logic signed [31:0] lerp_component(logic signed [31:0] va,
         logic signed [31:0] vb, longint frac);
      longint p;
      longint q;
      longint r;
      p = (longint'(vb) - longint'(va)) * frac;
      if (p >= 0) q = p / 65536;
      else q = -((-p + 65535) / 65536);
      r = longint'(va) + q;
      return r[31:0];
   endfunction

   function automatic sampled_point key_point(int i);
      sampled_point pt;
      pt.has = 1'b1;
      pt.x = kf_x[i];
      pt.y = kf_y[i];
      pt.z = kf_z[i];
      return pt;
   endfunction

   function automatic sampled_point sample_channel(logic signed [31:0] st);
      sampled_point pt;
      int n, lo, hi, mid, ia, ib;
      longint t, span, diff, frac;
      n = (shadow_count > MAX_KEYS) ? MAX_KEYS : int'(shadow_count);
      pt = '0;
      if (n == 0) return pt;
      if (n == 1) return key_point(0);
      t = wrap_sample_time(longint'(st));
      if (t <= longint'(kf_time[0])) return key_point(0);
      if (t >= longint'(kf_time[n-1])) return key_point(n - 1);
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (t < longint'(kf_time[mid])) hi = mid;
         else lo = mid + 1;
      end
      ib = lo;
      if (ib == 0) return key_point(0);
      if (ib >= n) return key_point(n - 1);
      ia = ib - 1;
      if (kf_hold[ia]) return key_point(ia);
      span = longint'(kf_time[ib]) - longint'(kf_time[ia]);
      if (span < SPAN_MIN) span = SPAN_MIN;
      diff = t - longint'(kf_time[ia]);
      if (diff <= 0) frac = 0;
      else begin
         frac = (diff <<< FRAC_W) / span;
         if (frac > 65536) frac = 65536;
      end
      pt.has = 1'b1;
      pt.x = lerp_component(kf_x[ia], kf_x[ib], frac);
      pt.y = lerp_component(kf_y[ia], kf_y[ib], frac);
      pt.z = lerp_component(kf_z[ia], kf_z[ib], frac);
      return pt;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   task automatic quiet_request();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // one transaction; the table and the expected points update on acceptance
   task automatic send_request(logic func, logic [5:0] idx, logic signed [31:0] kt,
         logic signed [31:0] kx, logic signed [31:0] ky, logic signed [31:0] kz,
         logic hold, logic signed [31:0] st, bit typed, sampled_point want);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_func = func;
      req_key_index = idx;
      req_key_time = kt;
      req_key_x = kx;
      req_key_y = ky;
      req_key_z = kz;
      req_key_hold = hold;
      req_sample_time = st;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (func == FUNC_WRITE) begin
         kf_time[idx] = (kt < 0) ? 32'sd0 : kt;
         kf_x[idx] = kx;
         kf_y[idx] = ky;
         kf_z[idx] = kz;
         kf_hold[idx] = hold;
         keys_sent++;
      end else begin
         pending_points.insert(pending_points.size(), typed ? want : sample_channel(st));
         samples_sent++;
      end
   endtask

   task automatic send_key(int idx, logic signed [31:0] kt, logic hold);
      send_request(FUNC_WRITE, idx[5:0], kt, $urandom, $urandom, $urandom, hold,
                   $urandom, 0, '0);
   endtask

   task automatic send_sample(logic signed [31:0] st);
      send_request(FUNC_SAMPLE, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
                   1'($urandom), st, 0, '0);
   endtask

   // register write, issued only once the block has drained
   task automatic write_register(reg_idx_type r, logic [31:0] v);
      quiet_request();
      wait (pending_points.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {r, 2'b00};
      csr_pwdata = v;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (r)
         REG_LOOP:  shadow_loop = v[0];
         REG_CLIP:  shadow_clip = v;
         REG_COUNT: shadow_count = v[6:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (long_hold_req && long_hold_left == 0) begin
         long_hold_left = 400;
         long_hold_req = 0;
      end
      if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %08h want %08h", cycles, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      sampled_point want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $display("unexpected result at cycle %0d", cycles);
            mismatches++;
         end else begin
            want = pending_points.pop_front();
            points_checked++;
            if (rsp_has_value !== want.has)
               report_mismatch("has_value", {31'd0, rsp_has_value}, {31'd0, want.has});
            if (rsp_value_x !== want.x) report_mismatch("value_x", rsp_value_x, want.x);
            if (rsp_value_y !== want.y) report_mismatch("value_y", rsp_value_y, want.y);
            if (rsp_value_z !== want.z) report_mismatch("value_z", rsp_value_z, want.z);
         end
      end
   end

   // ---------------------------------------------------------------------
   // directed table
   // ---------------------------------------------------------------------
   function automatic void add_key(int idx, logic [31:0] kt, logic [31:0] kx,
         logic [31:0] ky, logic [31:0] kz, logic hold);
      stim_row rw;
      rw = '{kind: ROW_KEY, ridx: REG_LOOP, default: '0};
      rw.idx = idx[5:0];
      rw.kt = kt;
      rw.kx = kx;
      rw.ky = ky;
      rw.kz = kz;
      rw.hold = hold;
      rows.insert(rows.size(), rw);
   endfunction

   function automatic void add_sample(logic [31:0] st, bit typed, sampled_point want);
      stim_row rw;
      rw = '{kind: ROW_SAMPLE, ridx: REG_LOOP, default: '0};
      rw.st = st;
      rw.typed = typed;
      rw.want = want;
      rows.insert(rows.size(), rw);
   endfunction

   function automatic void add_reg(reg_idx_type r, logic [31:0] v);
      stim_row rw;
      rw = '{kind: ROW_REG, ridx: r, default: '0};
      rw.rval = v;
      rows.insert(rows.size(), rw);
   endfunction

   function automatic void build_directed();
      sampled_point k0, k1;
      k0 = {1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000};
      k1 = {1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_2345};
      // empty table after reset
      add_sample(32'h0, 1, '0);
      // negative key time is stored as zero
      add_key(0, 32'hffff_ffff, k0.x, k0.y, k0.z, 1'b0);
      add_key(1, 32'h0001_0000, k1.x, k1.y, k1.z, 1'b1);
      add_key(2, 32'h0002_0000, 32'h0, 32'h0, 32'hffff_ffff, 1'b0);
      add_key(3, 32'h0002_0003, 32'h0001_0000, 32'hfff0_0000, 32'h7fff_ffff, 1'b0);
      // single key holds its value at any time
      add_reg(REG_COUNT, 32'd1);
      add_sample(32'h7fff_ffff, 1, k0);
      add_reg(REG_COUNT, 32'd4);
      add_reg(REG_LOOP, 32'd0);
      add_sample(32'h8000_0000, 1, k0);
      add_sample(32'h0000_8000, 0, '0);
      add_sample(32'h0000_0001, 0, '0);
      add_sample(32'h0001_8000, 1, k1);
      add_sample(32'h0002_0001, 0, '0);
      add_sample(32'h0002_0002, 0, '0);
      add_sample(32'h7fff_ffff, 0, '0);
      // clamp to clip length
      add_reg(REG_CLIP, 32'h0001_8000);
      add_sample(32'h7fff_ffff, 1, k1);
      add_sample(32'hffff_0000, 1, k0);
      // looping wraps negative and large times
      add_reg(REG_LOOP, 32'd1);
      add_sample(32'hffff_8000, 0, '0);
      add_sample(32'h0003_0000, 0, '0);
      add_reg(REG_CLIP, 32'hffff_ffff);
      add_sample(32'h8000_0000, 0, '0);
      add_sample(32'h7fff_ffff, 0, '0);
   endfunction

   // ---------------------------------------------------------------------
   // random phases
   // ---------------------------------------------------------------------
   // rebuild the whole table in non-decreasing time order
   task automatic load_sorted_keys(output longint last_t);
      longint t;
      int step_max;
      step_max = ($urandom_range(1)) ? 12 : 32'h40000;
      t = longint'($signed($urandom_range(32'h20000))) - 32'h8000;
      for (int i = 0; i < MAX_KEYS; i++) begin
         send_key(i, t[31:0], ($urandom_range(3) == 0));
         t += $urandom_range(step_max);
      end
      last_t = t;
   endtask

   function automatic logic [31:0] pick_time(longint span_end);
      longint lo, hi;
      if ($urandom_range(4) == 0) return $urandom;
      lo = -(span_end / 8) - 16;
      hi = span_end + span_end / 8 + 16;
      return 32'(lo + longint'($urandom_range(32'(hi - lo))));
   endfunction

   task automatic run_phase(int p);
      longint last_t;
      logic [31:0] clip;
      logic [6:0] count;
      case (p % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 65; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 65; end
         default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      load_sorted_keys(last_t);
      case (p)
         0: begin clip = '0;                 count = 7'd64;  end
         1: begin clip = 32'hffff_ffff;      count = 7'd127; end
         2: begin clip = 32'(last_t + 5);    count = 7'd64;  end
         3: begin clip = 32'(last_t / 2);    count = 7'd65;  end
         4: begin clip = 32'd1;              count = 7'd2;   end
         5: begin clip = 32'(last_t);        count = 7'($urandom_range(3, 63)); end
         6: begin clip = $urandom;           count = 7'd0;   end
         default: begin clip = 32'(last_t + 1); count = 7'd64; end
      endcase
      write_register(REG_LOOP, {16'($urandom_range(32'hffff)), 15'd0, p[0] ^ p[2]});
      write_register(REG_CLIP, clip);
      write_register(REG_COUNT, {25'd0, count});
      if (p == 2) long_hold_req = 1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         // noise: a stray key write, possibly out of order
         if ($urandom_range(9) == 0)
            send_key($urandom_range(63), $urandom, 1'($urandom_range(1)));
         else
            send_sample(pick_time(last_t));
         if (p == 5 && i % 60 == 59) begin
            quiet_request();
            wait (pending_points.size() == 0);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      stim_row rw;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      build_directed();
      foreach (rows[i]) begin
         rw = rows[i];
         case (rw.kind)
            ROW_KEY:    send_request(FUNC_WRITE, rw.idx, rw.kt, rw.kx, rw.ky, rw.kz,
                                     rw.hold, $urandom, 0, '0);
            ROW_SAMPLE: send_request(FUNC_SAMPLE, 6'($urandom), $urandom, $urandom,
                                     $urandom, $urandom, 1'($urandom), rw.st, rw.typed,
                                     rw.want);
            default:    write_register(rw.ridx, rw.rval);
         endcase
      end
      for (int p = 0; p < NUM_PHASES; p++) run_phase(p);
      quiet_request();
      wait (pending_points.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_points.size() != 0) begin
         $display("%0d expected results never arrived", pending_points.size());
         mismatches++;
      end
      $display("covered %0d samples and %0d key writes, %0d register writes",
               samples_sent, keys_sent, reg_writes);
      $display("checked %0d results, %0d mismatches", points_checked, mismatches);
      if (mismatches == 0) begin
         $display("** keyframe_channel_sampler_top: PASSED **");
      end else begin
         $display("** keyframe_channel_sampler_top: FAILED **");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/kcs_pkg.sv
hdl/kcs_front.sv
hdl/kcs_queue.sv
hdl/kcs_back.sv
hdl/keyframe_channel_sampler_top.sv
hdl/kcs_checker.sv
tb/tb_top.sv
